@@ design/cgi_pkg.sv @@
// shared types and constants for the color gradient interpolator
package cgi_pkg;

  localparam int unsigned TIME_W  = 16;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned KEY_W   = 48;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned FRAC_W  = 17;
  localparam int unsigned CH_W    = 8;

  localparam logic [IDX_W-1:0] REG_KEY_COUNT = 3'd0;
  localparam logic [IDX_W-1:0] REG_KEY_ZERO  = 3'd1;

  // one classified item on its way to the back end
  typedef struct packed {
    logic               direct;
    logic [COLOR_W-1:0] c_lo;
    logic [COLOR_W-1:0] c_hi;
    logic [TIME_W-1:0]  num;
    logic [TIME_W-1:0]  span;
  } job_t;

endpackage

@@ design/cgi_front.sv @@
// key registers and segment search for each incoming position
module cgi_front #(
  parameter int unsigned MAX_KEYS = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cgi_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [cgi_pkg::KEY_W-1:0]     cfg_data_i,
  input  logic [cgi_pkg::TIME_W-1:0]    position_i,
  output cgi_pkg::job_t                 job_o
);

  localparam int unsigned KIW = $clog2(MAX_KEYS);

  logic [cgi_pkg::IDX_W-1:0] count_q;
  logic [cgi_pkg::KEY_W-1:0] keys_q [MAX_KEYS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= cgi_pkg::IDX_W'(1);
      for (int k = 0; k < MAX_KEYS; k++) begin
        keys_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == cgi_pkg::REG_KEY_COUNT) begin
        count_q <= cfg_data_i[cgi_pkg::IDX_W-1:0];
      end else begin
        for (int k = 0; k < MAX_KEYS; k++) begin
          if (cfg_idx_i == cgi_pkg::IDX_W'(k) + cgi_pkg::REG_KEY_ZERO) begin
            keys_q[k] <= cfg_data_i;
          end
        end
      end
    end
  end

  logic [cgi_pkg::IDX_W-1:0]  n;
  logic [cgi_pkg::IDX_W-1:0]  last_idx;
  logic [cgi_pkg::KEY_W-1:0]  last_key;
  logic [cgi_pkg::TIME_W-1:0] t0, tl, t1, t2;
  logic                       found;
  logic [KIW-1:0]             seg;

  always_comb begin
    n = count_q;
    if (n == '0) n = cgi_pkg::IDX_W'(1);
    if (32'(n) > MAX_KEYS) n = cgi_pkg::IDX_W'(MAX_KEYS);
    last_idx = n - cgi_pkg::IDX_W'(1);
    last_key = keys_q[0];
    for (int k = 0; k < MAX_KEYS; k++) begin
      if (last_idx == cgi_pkg::IDX_W'(k)) last_key = keys_q[k];
    end
    t0 = keys_q[0][47:32];
    tl = last_key[47:32];
    // first bracketing pair wins
    found = 1'b0;
    seg   = '0;
    for (int i = 0; i < MAX_KEYS - 1; i++) begin
      if (!found && (cgi_pkg::IDX_W'(i + 1) < n)
          && position_i >= keys_q[i][47:32] && position_i <= keys_q[i+1][47:32]) begin
        found = 1'b1;
        seg   = KIW'(i);
      end
    end
    t1 = keys_q[seg][47:32];
    t2 = keys_q[KIW'(seg + KIW'(1))][47:32];

    job_o.c_lo   = keys_q[seg][31:0];
    job_o.c_hi   = keys_q[KIW'(seg + KIW'(1))][31:0];
    job_o.num    = position_i - t1;
    job_o.span   = t2 - t1;
    job_o.direct = 1'b0;
    if (position_i <= t0) begin
      job_o.direct = 1'b1;
      job_o.c_lo   = keys_q[0][31:0];
    end else if (position_i >= tl || !found) begin
      job_o.direct = 1'b1;
      job_o.c_lo   = last_key[31:0];
    end else if (t2 == t1) begin
      job_o.direct = 1'b1;
    end
  end

endmodule

@@ design/cgi_queue.sv @@
// two-entry item queue between front and back
module cgi_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cgi_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output cgi_pkg::job_t data_o
);

  cgi_pkg::job_t mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
    end
  end

endmodule

@@ design/cgi_back.sv @@
// fraction divider, channel lerp and result register
module cgi_back #(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_empty_i,
  input  cgi_pkg::job_t           job_i,
  output logic                    q_pop_o,
  output logic                    empty_o,
  input  logic                    pop_i,
  output logic [CHANNEL_BITS-1:0] red_o,
  output logic [CHANNEL_BITS-1:0] green_o,
  output logic [CHANNEL_BITS-1:0] blue_o,
  output logic [CHANNEL_BITS-1:0] alpha_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_LERP} state_e;

  state_e                          state_q;
  logic [4:0]                      cnt_q;
  logic [cgi_pkg::FRAC_W:0]        rem_q;
  logic [cgi_pkg::FRAC_W-1:0]      quo_q;
  logic [cgi_pkg::TIME_W-1:0]      span_q;
  logic [cgi_pkg::COLOR_W-1:0]     lo_q, hi_q;
  logic                            vld_q;
  logic [cgi_pkg::COLOR_W-1:0]     col_q;

  logic                            out_free;
  logic                            out_load;
  logic                            ge;
  logic [cgi_pkg::FRAC_W:0]        rem_n;
  logic [cgi_pkg::COLOR_W-1:0]     lerp;

  assign out_free = !vld_q || pop_i;
  assign empty_o  = !vld_q;
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i && (!job_i.direct || out_free);
  // result register takes a new color this cycle
  assign out_load = ((state_q == ST_IDLE) && q_pop_o && job_i.direct)
                    || ((state_q == ST_LERP) && out_free);

  // restoring division, one quotient bit per cycle
  assign ge    = rem_q >= {2'b00, span_q};
  assign rem_n = ge ? rem_q - {2'b00, span_q} : rem_q;

  always_comb begin
    logic signed [8:0]  d;
    logic signed [26:0] p;
    for (int c = 0; c < 4; c++) begin
      d = $signed({1'b0, hi_q[c*8 +: 8]}) - $signed({1'b0, lo_q[c*8 +: 8]});
      p = d * $signed({1'b0, quo_q});
      lerp[c*8 +: 8] = lo_q[c*8 +: 8] + p[23:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (out_load) vld_q <= 1'b1;
      else if (pop_i) vld_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (q_pop_o) begin
            if (job_i.direct) begin
              col_q <= job_i.c_lo;
            end else begin
              state_q <= ST_DIV;
              cnt_q   <= '0;
              rem_q   <= {2'b00, job_i.num};
              span_q  <= job_i.span;
              lo_q    <= job_i.c_lo;
              hi_q    <= job_i.c_hi;
            end
          end
        end
        ST_DIV: begin
          rem_q <= {rem_n[cgi_pkg::FRAC_W-1:0], 1'b0};
          quo_q <= {quo_q[cgi_pkg::FRAC_W-2:0], ge};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(cgi_pkg::FRAC_W - 1)) state_q <= ST_LERP;
        end
        ST_LERP: begin
          if (out_free) begin
            col_q   <= lerp;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign red_o   = CHANNEL_BITS'(col_q[31:24]);
  assign green_o = CHANNEL_BITS'(col_q[23:16]);
  assign blue_o  = CHANNEL_BITS'(col_q[15:8]);
  assign alpha_o = CHANNEL_BITS'(col_q[7:0]);

endmodule

@@ design/color_gradient_interpolator.sv @@
// top level of the color gradient interpolator
// Maps a 16-bit position to an RGBA color through up to MAX_KEYS keys.
// Input side is a queue: drive position_i with push, hold off while full.
// Result side is a queue: a color sits on red_o..alpha_o while empty is low,
// and pop takes it. Keys and key_count are written through cfg_we_i,
// cfg_idx_i and cfg_data_i while no item is in flight.
// The front end finds the bracketing key pair in the cycle an item is pushed
// and drops it into a two-entry queue. A position that lands on or beyond an
// end key, or on a zero-span pair, is written to the result register at the
// edge it leaves the queue. Any other item runs the bit-serial fraction
// divider for a 17-bit quotient and then the lerp step; the back end takes
// no new item until it is done, so the divider sets the throughput for
// interpolated items.
// When the receiver stalls the result register holds, the back end waits,
// the queue fills and full rises. Reset empties everything and sets one
// key at time zero with color zero.
module color_gradient_interpolator #(
  parameter int unsigned MAX_KEYS     = 7,
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cgi_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [cgi_pkg::KEY_W-1:0]     cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [cgi_pkg::TIME_W-1:0]    position_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [CHANNEL_BITS-1:0]       red_o,
  output logic [CHANNEL_BITS-1:0]       green_o,
  output logic [CHANNEL_BITS-1:0]       blue_o,
  output logic [CHANNEL_BITS-1:0]       alpha_o
);

  cgi_pkg::job_t job_in, job_out;
  logic          q_empty, q_pop;

  cgi_front #(.MAX_KEYS(MAX_KEYS)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .position_i, .job_o(job_in)
  );

  cgi_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(job_in), .full_o(full),
    .pop_i(q_pop), .empty_o(q_empty), .data_o(job_out)
  );

  cgi_back #(.CHANNEL_BITS(CHANNEL_BITS)) u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .job_i(job_out), .q_pop_o(q_pop),
    .empty_o(empty), .pop_i(pop),
    .red_o, .green_o, .blue_o, .alpha_o
  );

endmodule
